[hdl/chi_pkg.sv]
// ----------------------------------------------------------------------------
// chi_pkg: shared types and constants for the cuckoo hash insert block
// Field widths, register indexes, reset values, divider sizing and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package chi_pkg;

  // payload and register widths
  localparam int KEY_W   = 31;
  localparam int SIZE_W  = 11;
  localparam int LIMIT_W = 8;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SIZE_W;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_LIMIT = 1'd1;

  localparam logic [SIZE_W-1:0]  SIZE_RST  = 11'd1024;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 8'd100;

  // default table depth
  localparam int MAX_SLOTS_DEF = 1024;

  // divider: dividend padded to 32 bits, four quotient bits per cycle
  localparam int DVD_W      = 32;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_CYCLES = DVD_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  // table word: valid flag above the key
  localparam int WORD_W = KEY_W + 1;

  // divider operand select
  typedef enum logic [1:0] {
    DSEL_X  = 2'd0,  // key being placed
    DSEL_T1 = 2'd1,  // key just read from the first table
    DSEL_Q  = 2'd2   // quotient of the previous division
  } dsel_t;

  typedef struct packed {
    logic  clr_en;     // clearing pass: wipe one slot of each table
    logic  load_key;   // take a new key, clear round count and flag
    logic  div_start;
    dsel_t div_sel;
    logic  lat_i1;     // capture first-table index from divider
    logic  lat_i2;     // capture second-table index from divider
    logic  t1_rd;
    logic  t1_wr;      // write x into the first table
    logic  load_y;     // keep the evicted first-table key
    logic  t2_rd;
    logic  t2_wr;      // write y into the second table
    logic  load_z;     // evicted second-table key becomes x
    logic  next_round;
    logic  set_ok;
    logic  res_load;   // fill the output register
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic lim_hit;
    logic t1_hit;      // first-table slot occupied
    logic t2_hit;      // second-table slot occupied
  } sts_t;

endpackage

[hdl/chi_if.sv]
// ----------------------------------------------------------------------------
// chi_if: valid/ready channels of the cuckoo hash insert block
// Key channel in, result channel out.
// ----------------------------------------------------------------------------
interface chi_key_if;
  logic                     valid;
  logic                     ready;
  logic [chi_pkg::KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

interface chi_res_if;
  logic                     valid;
  logic                     ready;
  logic                     inserted;
  logic [chi_pkg::KEY_W-1:0] dropped_key;
  logic [chi_pkg::LIMIT_W-1:0] rounds_used;

  modport source (output valid, output inserted, output dropped_key, output rounds_used,
                  input ready);
  modport sink   (input valid, input inserted, input dropped_key, input rounds_used,
                  output ready);
endinterface

[hdl/chi_div.sv]
// ----------------------------------------------------------------------------
// chi_div: radix-16 restoring divider
// 31-bit dividend by 11-bit divisor, four quotient bits a cycle.
// ----------------------------------------------------------------------------
module chi_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [chi_pkg::KEY_W-1:0]   dividend,
  input  logic [chi_pkg::SIZE_W-1:0]  divisor,
  output logic                        done,
  output logic [chi_pkg::KEY_W-1:0]   quotient,
  output logic [chi_pkg::SIZE_W-1:0]  remainder
);

  localparam int SW = chi_pkg::SIZE_W;
  localparam int DW = chi_pkg::DVD_W;
  localparam logic [chi_pkg::DIV_CNT_W-1:0] CNT_LAST =
    chi_pkg::DIV_CNT_W'(chi_pkg::DIV_CYCLES - 1);

  logic                          busy_r;
  logic                          done_r;
  logic [chi_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [DW-1:0]                 dvd_r, dvd_v;
  logic [DW-1:0]                 quo_r, quo_v;
  logic [SW-1:0]                 rem_r, rem_v;
  logic [SW:0]                   trial;

  // four dependent shift/compare/subtract steps on 12-bit values
  always_comb begin
    dvd_v = dvd_r;
    quo_v = quo_r;
    rem_v = rem_r;
    trial = '0;
    for (int i = 0; i < chi_pkg::DIV_STEPS; i++) begin
      trial = {rem_v, dvd_v[DW-1]};
      dvd_v = {dvd_v[DW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_v = SW'(trial - {1'b0, divisor});
        quo_v = {quo_v[DW-2:0], 1'b1};
      end else begin
        rem_v = trial[SW-1:0];
        quo_v = {quo_v[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {1'b0, dividend};
      quo_r <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_v;
      quo_r <= quo_v;
      rem_r <= rem_v;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r[chi_pkg::KEY_W-1:0];
  assign remainder = rem_r;

endmodule

[hdl/chi_dp.sv]
// ----------------------------------------------------------------------------
// chi_dp: cuckoo hash insert datapath
// Config registers, both tables, working keys, round count, divider and
// output register.
// ----------------------------------------------------------------------------
module chi_dp #(
  parameter int MAX_SLOTS = chi_pkg::MAX_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  chi_pkg::cmd_t                   cmd,
  output chi_pkg::sts_t                   sts,
  input  logic                            cfg_we,
  input  logic [chi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [chi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [chi_pkg::KEY_W-1:0]       in_key,
  output logic                            res_inserted,
  output logic [chi_pkg::KEY_W-1:0]       res_dropped_key,
  output logic [chi_pkg::LIMIT_W-1:0]     res_rounds_used
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int KW    = chi_pkg::KEY_W;
  localparam int SW    = chi_pkg::SIZE_W;
  localparam int WW    = chi_pkg::WORD_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SLOTS - 1);

  logic [SW-1:0]                 size_r;
  logic [chi_pkg::LIMIT_W-1:0]   limit_r;
  logic [SW-1:0]                 m_eff;

  logic [IDX_W-1:0]              clr_addr_r;
  logic [KW-1:0]                 x_r, y_r;
  logic [IDX_W-1:0]              i1_r, i2_r;
  logic [chi_pkg::LIMIT_W-1:0]   round_r;
  logic                          ok_r;

  logic [WW-1:0]                 t1_mem [MAX_SLOTS];
  logic [WW-1:0]                 t2_mem [MAX_SLOTS];
  logic [WW-1:0]                 t1_q_r, t2_q_r;
  logic                          t1_we, t2_we;
  logic [IDX_W-1:0]              t1_wa, t2_wa;
  logic [WW-1:0]                 t1_wd, t2_wd;

  logic [KW-1:0]                 div_dvd;
  logic                          div_done;
  logic [KW-1:0]                 div_quo;
  logic [SW-1:0]                 div_rem;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= chi_pkg::SIZE_RST;
      limit_r <= chi_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        chi_pkg::REG_TABLE_SIZE:  size_r  <= cfg_wdata;
        chi_pkg::REG_ROUND_LIMIT: limit_r <= cfg_wdata[chi_pkg::LIMIT_W-1:0];
      endcase
    end
  end

  // modulus: size clamped to 1..MAX_SLOTS
  always_comb begin
    if (size_r == '0) begin
      m_eff = SW'(1);
    end else if (int'(size_r) > MAX_SLOTS) begin
      m_eff = SW'(MAX_SLOTS);
    end else begin
      m_eff = size_r;
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_en) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      chi_pkg::DSEL_X:  div_dvd = x_r;
      chi_pkg::DSEL_T1: div_dvd = t1_q_r[KW-1:0];
      chi_pkg::DSEL_Q:  div_dvd = div_quo;
      default:          div_dvd = x_r;
    endcase
  end

  chi_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (m_eff),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      x_r <= in_key;
    end else if (cmd.load_z) begin
      x_r <= t2_q_r[KW-1:0];
    end
    if (cmd.load_y) begin
      y_r <= t1_q_r[KW-1:0];
    end
    if (cmd.lat_i1) begin
      i1_r <= IDX_W'(div_rem);
    end
    if (cmd.lat_i2) begin
      i2_r <= IDX_W'(div_rem);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_r <= '0;
      ok_r    <= 1'b0;
    end else if (cmd.load_key) begin
      round_r <= '0;
      ok_r    <= 1'b0;
    end else begin
      if (cmd.next_round) begin
        round_r <= round_r + 1'b1;
      end
      if (cmd.set_ok) begin
        ok_r <= 1'b1;
      end
    end
  end

  // table ports: clearing pass or one write per eviction step
  assign t1_we = cmd.clr_en | cmd.t1_wr;
  assign t2_we = cmd.clr_en | cmd.t2_wr;
  assign t1_wa = cmd.clr_en ? clr_addr_r : i1_r;
  assign t2_wa = cmd.clr_en ? clr_addr_r : i2_r;
  assign t1_wd = cmd.clr_en ? '0 : {1'b1, x_r};
  assign t2_wd = cmd.clr_en ? '0 : {1'b1, y_r};

  always_ff @(posedge clk) begin
    if (t1_we) begin
      t1_mem[t1_wa] <= t1_wd;
    end
    if (cmd.t1_rd) begin
      t1_q_r <= t1_mem[i1_r];
    end
  end

  always_ff @(posedge clk) begin
    if (t2_we) begin
      t2_mem[t2_wa] <= t2_wd;
    end
    if (cmd.t2_rd) begin
      t2_q_r <= t2_mem[i2_r];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_inserted    <= ok_r;
      res_dropped_key <= ok_r ? '0 : x_r;
      res_rounds_used <= round_r;
    end
  end

  assign sts.clr_last = (clr_addr_r == IDX_LAST);
  assign sts.div_done = div_done;
  assign sts.lim_hit  = (round_r == limit_r);
  assign sts.t1_hit   = t1_q_r[WW-1];
  assign sts.t2_hit   = t2_q_r[WW-1];

endmodule

[hdl/chi_ctrl.sv]
// ----------------------------------------------------------------------------
// chi_ctrl: cuckoo hash insert controller
// Sequences the clearing pass, the eviction rounds and the output handshake.
// ----------------------------------------------------------------------------
module chi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  chi_pkg::sts_t sts,
  output chi_pkg::cmd_t cmd
);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_CHECK = 11'b000_0000_0100,
    S_DIV1  = 11'b000_0000_1000,
    S_RD1   = 11'b000_0001_0000,
    S_EV1   = 11'b000_0010_0000,
    S_DIVQ  = 11'b000_0100_0000,
    S_DIVR  = 11'b000_1000_0000,
    S_RD2   = 11'b001_0000_0000,
    S_EV2   = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    cmd.div_sel   = chi_pkg::DSEL_X;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_key = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.lim_hit) begin
          state_nxt = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = chi_pkg::DSEL_X;
          state_nxt     = S_DIV1;
        end
      end
      S_DIV1: begin
        if (sts.div_done) begin
          cmd.lat_i1 = 1'b1;
          state_nxt  = S_RD1;
        end
      end
      S_RD1: begin
        cmd.t1_rd = 1'b1;
        state_nxt = S_EV1;
      end
      S_EV1: begin
        cmd.t1_wr = 1'b1;
        if (!sts.t1_hit) begin
          cmd.set_ok = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          cmd.load_y    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = chi_pkg::DSEL_T1;
          state_nxt     = S_DIVQ;
        end
      end
      S_DIVQ: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = chi_pkg::DSEL_Q;
          state_nxt     = S_DIVR;
        end
      end
      S_DIVR: begin
        if (sts.div_done) begin
          cmd.lat_i2 = 1'b1;
          state_nxt  = S_RD2;
        end
      end
      S_RD2: begin
        cmd.t2_rd = 1'b1;
        state_nxt = S_EV2;
      end
      S_EV2: begin
        cmd.t2_wr = 1'b1;
        if (!sts.t2_hit) begin
          cmd.set_ok = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          cmd.load_z     = 1'b1;
          cmd.next_round = 1'b1;
          state_nxt      = S_CHECK;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[hdl/cuckoo_hash_insert.sv]
// ----------------------------------------------------------------------------
// cuckoo_hash_insert: two-table cuckoo hash insertion
// Each key goes to slot key mod size of the first table; a displaced key moves
// to slot (key div size) mod size of the second table, whose occupant starts
// the next round. One result per key: inserted flag, dropped key, rounds.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    key[30:0]
//   out_ch   out  valid/ready    inserted, dropped_key[30:0], rounds_used[7:0]
//   cfg_*    in   cfg_we         cfg_index[0], cfg_wdata[10:0]
//
// One key in flight at a time. Each round runs the divider once for the
// first-table index and, when that slot is taken, twice more for the
// second-table index (two mods, one div). After reset a clearing pass
// empties all MAX_SLOTS slots of both tables; no key is taken meanwhile.
// A stalled result sits in the output register; the next key is taken while
// it waits and finishes once it has been transferred.
// ----------------------------------------------------------------------------
module cuckoo_hash_insert #(
  parameter int MAX_SLOTS = chi_pkg::MAX_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  chi_key_if.sink                         in_ch,
  chi_res_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [chi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [chi_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  chi_pkg::cmd_t cmd;
  chi_pkg::sts_t sts;

  // sequencer: clearing pass, round loop, result handshake
  chi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // tables, divider, working keys and output register
  chi_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_key          (in_ch.key),
    .res_inserted    (out_ch.inserted),
    .res_dropped_key (out_ch.dropped_key),
    .res_rounds_used (out_ch.rounds_used)
  );

endmodule

[hdl/chi_checker.sv]
// ----------------------------------------------------------------------------
// chi_checker: port-level checks for cuckoo_hash_insert
// Handshake hold rules, one key in flight, result coding, reset clearing.
// ----------------------------------------------------------------------------
module chi_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_inserted,
  input logic [chi_pkg::KEY_W-1:0]     out_dropped_key,
  input logic [chi_pkg::LIMIT_W-1:0]   out_rounds_used
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_inserted) && $stable(out_dropped_key) && $stable(out_rounds_used))
    else $error("result payload changed while stalled");

  // one key at a time
  a_one_key: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second key taken while one is in flight");

  a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inserted |-> out_dropped_key == '0)
    else $error("dropped key set on success");

  // tables are cleared before any key is taken
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("key accepted during clearing pass");

endmodule

bind cuckoo_hash_insert chi_checker u_chi_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_inserted    (out_ch.inserted),
  .out_dropped_key (out_ch.dropped_key),
  .out_rounds_used (out_ch.rounds_used)
);

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for cuckoo_hash_insert
// Keys go in over a valid/ready channel from a queue filled by the stimulus
// process. A local two-table cuckoo predictor works out each outcome on every
// key transfer, and the result monitor checks each transfer against it.
// Size and round limit are changed between phases, only while the block idles.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = chi_pkg::MAX_SLOTS_DEF;
  localparam logic [chi_pkg::KEY_W-1:0] KEY_ALL = '1;
  localparam int DRAIN = 8;        // cycles after the last result before a register write
  localparam int TAIL = 100;       // quiet cycles at the end, to catch stray results
  localparam int HOLD_CYCLES = 500;
  localparam int HOLD_AT = 60;     // result count that triggers the long receiver stall
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic                        inserted;
    logic [chi_pkg::KEY_W-1:0]   dropped_key;
    logic [chi_pkg::LIMIT_W-1:0] rounds_used;
  } outcome_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [chi_pkg::CFG_IDX_W-1:0]  cfg_index = chi_pkg::REG_TABLE_SIZE;
  logic [chi_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  chi_key_if key_ch();
  chi_res_if res_ch();

  cuckoo_hash_insert #(.MAX_SLOTS(SLOTS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (key_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: both tables with their occupied flags, plus the
  // register values the block should be using.
  // --------------------------------------------------------------------------
  bit [chi_pkg::KEY_W-1:0]     t1_key  [SLOTS];
  bit                          t1_used [SLOTS];
  bit [chi_pkg::KEY_W-1:0]     t2_key  [SLOTS];
  bit                          t2_used [SLOTS];
  logic [chi_pkg::SIZE_W-1:0]  size_reg  = chi_pkg::SIZE_RST;
  logic [chi_pkg::LIMIT_W-1:0] limit_reg = chi_pkg::LIMIT_RST;

  logic [chi_pkg::KEY_W-1:0] keys_to_send[$];   // stimulus not yet offered
  outcome_t                  outcomes_due[$];   // predicted results, oldest first
  logic [chi_pkg::KEY_W-1:0] recent_keys[$];    // pool for repeated keys

  int unsigned n_sent, n_checked, n_placed, n_dropped, n_errors, deepest, n_settings;
  int unsigned send_gap, recv_gap, hold_left;
  bit          idle_on;
  bit          hold_done;

  // size 0 acts as 1, anything past the table depth as the full depth
  function automatic int unsigned eff_size();
    int unsigned m;
    m = 32'(size_reg);
    if (m == 0) m = 1;
    if (m > SLOTS) m = SLOTS;
    return m;
  endfunction

  // One insertion: place in the first table, push any occupant to the second,
  // and keep bouncing the second-table occupant until a slot is free or the
  // round limit is reached. Keys placed on the way stay, even on failure.
  function automatic outcome_t cuckoo_insert(logic [chi_pkg::KEY_W-1:0] key);
    int unsigned m, x, y, z, i1, i2, rnd;
    bit          done;
    outcome_t    res;
    m = eff_size();
    x = 32'(key);
    rnd = 0;
    done = 1'b0;
    while (!done && rnd < 32'(limit_reg)) begin
      i1 = x % m;
      if (!t1_used[i1]) begin
        t1_key[i1] = chi_pkg::KEY_W'(x);
        t1_used[i1] = 1'b1;
        done = 1'b1;
      end else begin
        y = 32'(t1_key[i1]);
        t1_key[i1] = chi_pkg::KEY_W'(x);
        i2 = (y / m) % m;
        if (!t2_used[i2]) begin
          t2_key[i2] = chi_pkg::KEY_W'(y);
          t2_used[i2] = 1'b1;
          done = 1'b1;
        end else begin
          z = 32'(t2_key[i2]);
          t2_key[i2] = chi_pkg::KEY_W'(y);
          x = z;
          rnd++;
        end
      end
    end
    res.inserted    = done;
    res.dropped_key = done ? '0 : chi_pkg::KEY_W'(x);
    res.rounds_used = chi_pkg::LIMIT_W'(rnd);
    return res;
  endfunction

  // no gaps unless idle_on is set; then mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Key mix: plain random, keys sharing a few first-table slots (forces
  // evictions), the ends of the range, and repeats of recent keys.
  function automatic logic [chi_pkg::KEY_W-1:0] gen_key(int unsigned m);
    int unsigned               r, base, span;
    logic [chi_pkg::KEY_W-1:0] k;
    r = $urandom_range(0, 9);
    span = (m < 16) ? m : 16;
    if (r < 4 || r == 9) begin
      k = chi_pkg::KEY_W'($urandom);
    end else if (r < 7) begin
      base = $urandom & 32'h7FFF_FFFF;
      k = chi_pkg::KEY_W'(base - base % m + $urandom_range(0, span - 1));
    end else if (r == 7) begin
      case ($urandom_range(0, 3))
        0:       k = '0;
        1:       k = KEY_ALL;
        2:       k = chi_pkg::KEY_W'($urandom_range(0, 15));
        default: k = KEY_ALL - chi_pkg::KEY_W'($urandom_range(0, 15));
      endcase
    end else if (recent_keys.size() > 0) begin
      k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    end else begin
      k = chi_pkg::KEY_W'($urandom);
    end
    return k;
  endfunction

  function automatic void push_key(logic [chi_pkg::KEY_W-1:0] k);
    keys_to_send.push_back(k);
    recent_keys.push_back(k);
    if (recent_keys.size() > 64) void'(recent_keys.pop_front());
  endfunction

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Key driver. A new key is put up only when the channel is free (nothing
  // shown, or the shown key transferring now). The gap drawn with a key runs
  // after that key has transferred.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      key_ch.valid <= 1'b0;
    end else begin
      if (key_ch.valid && key_ch.ready) begin
        outcomes_due.push_back(cuckoo_insert(key_ch.key));
        n_sent++;
      end
      if (!key_ch.valid || key_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          key_ch.valid <= 1'b0;
        end else if (keys_to_send.size() > 0) begin
          key_ch.valid <= 1'b1;
          key_ch.key   <= keys_to_send.pop_front();
          send_gap = pick_gap();
        end else begin
          key_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: checks each transfer against the oldest prediction and
  // drives ready with random gaps. Once, after HOLD_AT results, ready stays
  // low for HOLD_CYCLES so the block backs up and stalls the key channel.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_mon
    outcome_t want, got;
    bit       took;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      took = res_ch.valid && res_ch.ready;
      if (took) begin
        got.inserted    = res_ch.inserted;
        got.dropped_key = res_ch.dropped_key;
        got.rounds_used = res_ch.rounds_used;
        if (outcomes_due.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: unexpected result: expected none, actual %0d/%0h/%0d",
                     $time, got.inserted, got.dropped_key, got.rounds_used);
        end else begin
          want = outcomes_due.pop_front();
          report_field("inserted", 32'(want.inserted), 32'(got.inserted));
          report_field("dropped_key", 32'(want.dropped_key), 32'(got.dropped_key));
          report_field("rounds_used", 32'(want.rounds_used), 32'(got.rounds_used));
        end
        n_checked++;
        if (got.inserted) n_placed++;
        else n_dropped++;
        if (32'(got.rounds_used) > deepest) deepest = 32'(got.rounds_used);
        if (!hold_done && n_checked == HOLD_AT) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        res_ch.ready <= 1'b0;
      end else begin
        // gaps start after transfers and now and then at random, so they
        // also land while the block is still busy
        if (took || $urandom_range(0, 7) == 0) recv_gap = pick_gap();
        res_ch.ready <= (recv_gap == 0);
      end
    end
  end

  // everything sent, every transfer seen, then a short drain
  task automatic wait_idle();
    do @(negedge clk);
    while (keys_to_send.size() != 0 || key_ch.valid || outcomes_due.size() != 0);
    repeat (DRAIN) @(negedge clk);
  endtask

  // Register writes only when the block is idle. Upper data bits of the
  // round-limit write are random; the block must ignore them.
  task automatic configure(int unsigned size, int unsigned lim);
    logic [chi_pkg::CFG_DATA_W-1:0] wd;
    wait_idle();
    wd = chi_pkg::CFG_DATA_W'($urandom);
    wd[chi_pkg::LIMIT_W-1:0] = lim[chi_pkg::LIMIT_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= chi_pkg::REG_TABLE_SIZE;
    cfg_wdata <= size[chi_pkg::SIZE_W-1:0];
    @(posedge clk);
    cfg_index <= chi_pkg::REG_ROUND_LIMIT;
    cfg_wdata <= wd;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_reg  = size[chi_pkg::SIZE_W-1:0];
    limit_reg = wd[chi_pkg::LIMIT_W-1:0];
    n_settings++;
    @(negedge clk);
  endtask

  task automatic run_phase(int unsigned size, int unsigned lim, int unsigned count, bit idle);
    configure(size, lim);
    idle_on = idle;
    repeat (count) push_key(gen_key(eff_size()));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    key_ch.valid = 1'b0;
    key_ch.key   = '0;
    res_ch.ready = 1'b0;
    idle_on = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset settings (size 1024, limit 100). Keys sit behind the
    // clearing pass until the block takes them.
    push_key('0);
    push_key(KEY_ALL);
    push_key(chi_pkg::KEY_W'(1024));   // same first slot as 0: evicts it
    push_key(chi_pkg::KEY_W'(2048));   // evicts 1024 to the second table
    push_key(chi_pkg::KEY_W'(2048));   // same key again takes a second slot
    push_key(chi_pkg::KEY_W'(1));
    push_key(chi_pkg::KEY_W'(1025));   // chain through occupied second-table slots
    push_key(KEY_ALL - chi_pkg::KEY_W'(1023));
    // limit zero: nothing placed, key comes straight back
    configure(1024, 0);
    push_key(KEY_ALL);
    push_key(chi_pkg::KEY_W'(5));
    // one slot per table, one round: fails as soon as both are full
    configure(1, 1);
    push_key(chi_pkg::KEY_W'(10));
    push_key(chi_pkg::KEY_W'(20));
    push_key(chi_pkg::KEY_W'(30));
    // size zero behaves as size one
    configure(0, 3);
    push_key(chi_pkg::KEY_W'(7));
    push_key(chi_pkg::KEY_W'(8));
    // full-length failure: 255 rounds
    configure(1, 255);
    push_key(chi_pkg::KEY_W'(12345));
    // size above the table depth is clamped; contents from other sizes stay
    configure(2047, 2);
    push_key(KEY_ALL);
    push_key(chi_pkg::KEY_W'(3));

    // Random phases; most keep the round limit modest since every failure
    // costs three divider runs per round.
    run_phase(1024, 100, 300, 1'b1);
    run_phase(1,      1,  40, 1'b1);
    run_phase(0,      5,  40, 1'b0);
    run_phase(2047, 255,  50, 1'b1);
    run_phase(7,     12, 150, 1'b1);
    run_phase(1024,   0,  40, 1'b1);
    run_phase(300,   20, 150, 1'b1);
    run_phase(1024,  40, 300, 1'b1);
    run_phase(1000,  40, 280, 1'b0);
    run_phase(64,     8, 150, 1'b1);
    run_phase(1024, 255,  30, 1'b1);
    run_phase(2,      3, 100, 1'b1);

    wait_idle();
    repeat (TAIL) @(negedge clk);
    if (outcomes_due.size() != 0) n_errors++;

    $display("%0d keys sent, %0d results checked over %0d register settings",
             n_sent, n_checked, n_settings);
    $display("%0d placed, %0d dropped, longest chain %0d rounds, one %0d-cycle output stall",
             n_placed, n_dropped, deepest, HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hang guard: several times the slowest legal run of this stimulus
  initial begin
    #150_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
